@@ src/token_bucket_frame_pacer_macros.svh @@
// assertion helpers for the pacer rtl
`ifndef TOKEN_BUCKET_FRAME_PACER_MACROS_SVH
`define TOKEN_BUCKET_FRAME_PACER_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication, checked at every rising edge out of reset
`define TBFP_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("pacer check failed");

// next-cycle implication
`define TBFP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("pacer check failed");

`else

`define TBFP_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`define TBFP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

@@ src/tbfp_pkg.sv @@
`default_nettype none
package tbfp_pkg;

	// field and state widths
	localparam int TIME_W     = 64;
	localparam int BUF_W      = 7;
	localparam int IDX_W      = 16;
	localparam int RATE_W     = 32;
	localparam int WC_W       = 8;
	localparam int CREDIT_W   = 44;
	localparam int ELAPSED_W  = 44;
	localparam int THR_W      = 38;
	localparam int NSEC_W     = 30;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	// cost of one emission per worker
	localparam logic [NSEC_W-1:0] NS_PER_SEC = NSEC_W'(1000000000);

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_N_FRAMES  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PKT_RATE  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_N_WORKERS = 2'd2;

	typedef struct packed {
		logic [IDX_W-1:0]  n_frames;
		logic [RATE_W-1:0] pkt_rate;
		logic [WC_W-1:0]   n_workers;
	} cfg_t;

	// one tick handed from front to back
	typedef struct packed {
		logic [ELAPSED_W-1:0] elapsed;
		logic                 elapsed_over;
		logic [BUF_W-1:0]     bufs;
	} cmd_t;

	typedef struct packed {
		logic valid;
		logic full;
	} q_stat_t;

	typedef struct packed {
		logic busy;
		logic pop;
	} back_stat_t;

endpackage
`default_nettype wire

@@ src/tbfp_if.sv @@
`default_nettype none
// tick channel
interface tbfp_in_if import tbfp_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [TIME_W-1:0] now_ns;
	logic [BUF_W-1:0]  free_buffers;

	modport source(output valid, output now_ns, output free_buffers, input ready);
	modport sink(input valid, input now_ns, input free_buffers, output ready);
endinterface

// frame index channel
interface tbfp_out_if import tbfp_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [IDX_W-1:0] frame_index;
	logic             last;

	modport source(output valid, output frame_index, output last, input ready);
	modport sink(input valid, input frame_index, input last, output ready);
endinterface
`default_nettype wire

@@ src/token_bucket_frame_pacer.sv @@
// throughput: one frame index per cycle while the back end is emitting and the sink
//   is ready; before emitting, the back end runs the split elapsed-times-rate
//   multiply and a 16-step cursor modulo
// reset: arst_n clears configuration, clock anchor, credit, cursor and queue
`default_nettype none
`include "token_bucket_frame_pacer_macros.svh"
module token_bucket_frame_pacer import tbfp_pkg::*; #(
	parameter int BURST_LIMIT = 64
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
	tbfp_in_if.sink                    ticks,
	tbfp_out_if.source                 frames
);

	cfg_t       cfg_q;
	logic       push;
	cmd_t       push_cmd;
	cmd_t       head_cmd;
	q_stat_t    qs;
	back_stat_t bs;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_N_FRAMES:  cfg_q.n_frames  <= cfg_wdata[IDX_W-1:0];
				CFG_PKT_RATE:  cfg_q.pkt_rate  <= cfg_wdata[RATE_W-1:0];
				CFG_N_WORKERS: cfg_q.n_workers <= cfg_wdata[WC_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// tick intake and classification
	tbfp_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.ticks  (ticks),
		.qs     (qs),
		.push   (push),
		.cmd    (push_cmd)
	);

	// decoupling queue
	tbfp_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (bs.pop),
		.head_cmd (head_cmd),
		.qs       (qs)
	);

	// credit update and emission
	tbfp_back #(
		.BURST_LIMIT (BURST_LIMIT)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.qs       (qs),
		.head_cmd (head_cmd),
		.bs       (bs),
		.frames   (frames)
	);

	// queue never overruns or underruns
	`TBFP_ASSERT_IMPLIES(a_push_not_full, clk, arst_n, push, !qs.full)
	`TBFP_ASSERT_IMPLIES(a_pop_has_entry, clk, arst_n, bs.pop, qs.valid && !bs.busy)
	// a pop always starts the back end
	`TBFP_ASSERT_NEXT(a_pop_starts_back, clk, arst_n, bs.pop, bs.busy)

endmodule
`default_nettype wire

@@ src/tbfp_front.sv @@
`default_nettype none
module tbfp_front import tbfp_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire cfg_t  cfg,
	tbfp_in_if.sink    ticks,
	input  wire q_stat_t qs,
	output logic       push,
	output cmd_t       cmd
);

	logic [TIME_W-1:0] last_time_q;
	logic              accept;
	logic              enabled;
	logic              later;
	logic [TIME_W-1:0] diff;

	assign ticks.ready = !qs.full;
	assign accept      = ticks.valid && ticks.ready;
	assign enabled     = (cfg.n_frames != '0) && (cfg.pkt_rate != '0)
		&& (cfg.n_workers != '0);

	// elapsed time, zero unless time moves forward
	assign later = ticks.now_ns > last_time_q;
	assign diff  = later ? (ticks.now_ns - last_time_q) : '0;

	assign push             = accept && enabled && (last_time_q != '0);
	assign cmd.elapsed      = diff[ELAPSED_W-1:0];
	assign cmd.elapsed_over = |diff[TIME_W-1:ELAPSED_W];
	assign cmd.bufs         = ticks.free_buffers;

	// clock anchor, taken on every enabled tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_time_q <= '0;
		end else if (accept && enabled) begin
			last_time_q <= ticks.now_ns;
		end
	end

endmodule
`default_nettype wire

@@ src/tbfp_queue.sv @@
`default_nettype none
module tbfp_queue import tbfp_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire cmd_t push_cmd,
	input  wire logic pop,
	output cmd_t      head_cmd,
	output q_stat_t   qs
);

	cmd_t       entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign head_cmd = entry_q[rd_ptr_q];
	assign qs.valid = count_q != 2'd0;
	assign qs.full  = count_q == 2'd2;

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule
`default_nettype wire

@@ src/tbfp_back.sv @@
`default_nettype none
module tbfp_back import tbfp_pkg::*; #(
	parameter int BURST_LIMIT = 64
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire cfg_t    cfg,
	input  wire q_stat_t qs,
	input  wire cmd_t    head_cmd,
	output back_stat_t   bs,
	tbfp_out_if.source   frames
);

	localparam int CNT_W  = $clog2(BURST_LIMIT + 1);
	localparam int CMP_W  = 8;
	localparam int PROD_W = ELAPSED_W + RATE_W;

	typedef enum logic [2:0] {
		S_IDLE,
		S_MUL_LO,
		S_MUL_HI,
		S_SUM,
		S_SAT,
		S_MOD,
		S_EMIT
	} state_t;

	state_t                 state_q;
	logic [CREDIT_W-1:0]    credit_q;
	logic [IDX_W-1:0]       cursor_q;
	logic [ELAPSED_W-1:0]   el_q;
	logic                   over_q;
	logic [BUF_W-1:0]       bufs_q;
	logic [THR_W-1:0]       thr_q;
	logic [CREDIT_W-1:0]    cap_q;
	logic [CREDIT_W-1:0]    room_q;
	logic                   full_q;
	logic [2*RATE_W-1:0]    p_lo_q;
	logic [CREDIT_W-1:0]    p_hi_q;
	logic [PROD_W-1:0]      prod_q;
	logic [IDX_W-1:0]       rem_q;
	logic [3:0]             bit_q;
	logic [CNT_W-1:0]       cnt_q;
	logic                   out_valid_q;
	logic [IDX_W-1:0]       out_idx_q;
	logic                   out_last_q;

	logic                   slot_free;
	logic [IDX_W:0]         rem_sh;
	logic [IDX_W:0]         rem_sub;
	logic [IDX_W-1:0]       rem_next;
	logic [IDX_W:0]         pos_inc;
	logic [IDX_W-1:0]       pos_next;
	logic [CREDIT_W-1:0]    thr_ext;
	logic [CREDIT_W-1:0]    credit_left;
	logic                   go;
	logic                   no_buf;
	logic                   more;
	logic                   fire;

	assign bs.busy = state_q != S_IDLE;
	assign bs.pop  = (state_q == S_IDLE) && qs.valid;

	assign frames.valid       = out_valid_q;
	assign frames.frame_index = out_idx_q;
	assign frames.last        = out_last_q;
	assign slot_free          = !out_valid_q || frames.ready;

	// one restoring step of cursor mod n_frames
	assign rem_sh   = {rem_q, cursor_q[bit_q]};
	assign rem_sub  = rem_sh - {1'b0, cfg.n_frames};
	assign rem_next = (rem_sh >= {1'b0, cfg.n_frames}) ? rem_sub[IDX_W-1:0]
		: rem_sh[IDX_W-1:0];

	// rotation over the loaded frames
	assign pos_inc  = {1'b0, cursor_q} + {{IDX_W{1'b0}}, 1'b1};
	assign pos_next = (pos_inc >= {1'b0, cfg.n_frames}) ? '0 : pos_inc[IDX_W-1:0];

	// emission conditions and lookahead for the last flag
	assign thr_ext     = CREDIT_W'(thr_q);
	assign credit_left = credit_q - thr_ext;
	assign go          = (credit_q >= thr_ext) && (cnt_q < CNT_W'(BURST_LIMIT));
	assign no_buf      = CMP_W'(cnt_q) >= CMP_W'(bufs_q);
	assign more        = (credit_left >= thr_ext)
		&& ((CMP_W'(cnt_q) + CMP_W'(1)) < CMP_W'(BURST_LIMIT))
		&& ((CMP_W'(cnt_q) + CMP_W'(1)) < CMP_W'(bufs_q));
	assign fire        = (state_q == S_EMIT) && go && !no_buf && slot_free;

	// sequencer, credit and cursor state, output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			credit_q    <= '0;
			cursor_q    <= '0;
			out_valid_q <= 1'b0;
			out_idx_q   <= '0;
			out_last_q  <= 1'b0;
			cnt_q       <= '0;
			bit_q       <= '0;
			rem_q       <= '0;
			el_q        <= '0;
			over_q      <= 1'b0;
			bufs_q      <= '0;
			thr_q       <= '0;
			cap_q       <= '0;
			room_q      <= '0;
			full_q      <= 1'b0;
			p_lo_q      <= '0;
			p_hi_q      <= '0;
			prod_q      <= '0;
		end else begin
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (frames.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (qs.valid) begin
						el_q    <= head_cmd.elapsed;
						over_q  <= head_cmd.elapsed_over;
						bufs_q  <= head_cmd.bufs;
						thr_q   <= THR_W'(NS_PER_SEC) * THR_W'(cfg.n_workers);
						state_q <= S_MUL_LO;
					end
				end
				S_MUL_LO: begin
					p_lo_q  <= (2*RATE_W)'(el_q[RATE_W-1:0]) * (2*RATE_W)'(cfg.pkt_rate);
					cap_q   <= CREDIT_W'(thr_q) * CREDIT_W'(BURST_LIMIT);
					state_q <= S_MUL_HI;
				end
				S_MUL_HI: begin
					p_hi_q  <= CREDIT_W'(el_q[ELAPSED_W-1:RATE_W]) * CREDIT_W'(cfg.pkt_rate);
					room_q  <= cap_q - credit_q;
					full_q  <= credit_q >= cap_q;
					state_q <= S_SUM;
				end
				S_SUM: begin
					prod_q  <= PROD_W'(p_lo_q) + {p_hi_q, {RATE_W{1'b0}}};
					state_q <= S_SAT;
				end
				S_SAT: begin
					// saturate at the cap, else add the earned credit
					if (full_q || over_q || (prod_q >= PROD_W'(room_q))) begin
						credit_q <= cap_q;
					end else begin
						credit_q <= credit_q + prod_q[CREDIT_W-1:0];
					end
					rem_q   <= '0;
					bit_q   <= 4'(IDX_W - 1);
					state_q <= S_MOD;
				end
				S_MOD: begin
					rem_q <= rem_next;
					bit_q <= bit_q - 4'd1;
					if (bit_q == 4'd0) begin
						cursor_q <= rem_next;
						cnt_q    <= '0;
						state_q  <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (!go) begin
						state_q <= S_IDLE;
					end else if (no_buf) begin
						// out of buffers: this frame is skipped
						cursor_q <= pos_next;
						state_q  <= S_IDLE;
					end else if (slot_free) begin
						out_idx_q   <= cursor_q;
						out_last_q  <= !more;
						credit_q    <= credit_left;
						cursor_q    <= pos_next;
						cnt_q       <= cnt_q + CNT_W'(1);
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

@@ bench/token_bucket_frame_pacer_tb.sv @@
`timescale 1ns / 1ps
module token_bucket_frame_pacer_tb;
	import tbfp_pkg::*;

	localparam int FRAME_BURST  = 64;
	localparam int QUIET_CYCLES = 300;

	typedef struct packed {
		logic [IDX_W-1:0] frame_index;
		logic             last;
	} frame_beat_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	tbfp_in_if  ticks ();
	tbfp_out_if frames ();

	token_bucket_frame_pacer #(
		.BURST_LIMIT(FRAME_BURST)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.ticks    (ticks),
		.frames   (frames)
	);

	// shadow of the pacer registers and state
	cfg_t                 pacer_cfg = '0;
	logic [TIME_W-1:0]    anchor_ns = '0;
	logic [CREDIT_W-1:0]  credit_acc = '0;
	logic [IDX_W-1:0]     cursor = '0;

	frame_beat_t pending_frames[$];

	bit                idle_on = 1'b1;
	int                stall_left = 0;
	int                errors = 0;
	int                ticks_sent = 0;
	int                frames_checked = 0;
	int                cfg_writes = 0;
	logic [TIME_W-1:0] stim_ns = '0;

	always #5 clk = ~clk;

	// expected frame indices for one accepted tick
	function automatic void pace_frames(input logic [TIME_W-1:0] now, input logic [BUF_W-1:0] bufs);
		logic [63:0]      elapsed;
		logic [63:0]      thr;
		logic [63:0]      cap;
		logic [63:0]      c;
		logic [63:0]      room;
		logic [63:0]      pos;
		logic [63:0]      idx;
		logic [63:0]      rate;
		logic [63:0]      fc;
		int               sent;
		bit               have;
		frame_beat_t      beat;
		if (pacer_cfg.n_frames == 0 || pacer_cfg.pkt_rate == 0 ||
				pacer_cfg.n_workers == 0)
			return;
		// first enabled tick only anchors the clock
		if (anchor_ns == 0) begin
			anchor_ns = now;
			return;
		end
		elapsed = (now > anchor_ns) ? now - anchor_ns : 64'd0;
		anchor_ns = now;
		rate = 64'(pacer_cfg.pkt_rate);
		fc   = 64'(pacer_cfg.n_frames);
		thr  = 64'(NS_PER_SEC) * 64'(pacer_cfg.n_workers);
		cap  = thr * 64'(FRAME_BURST);
		// credit refill, saturating at the burst cap
		c = 64'(credit_acc);
		if (c >= cap) begin
			c = cap;
		end else begin
			room = cap - c;
			if (elapsed != 0 && rate > room / elapsed)
				c = cap;
			else if (elapsed * rate >= room)
				c = cap;
			else
				c = c + elapsed * rate;
		end
		// emit in rotation; the frame at which buffers run out is skipped
		pos = 64'(cursor) % fc;
		sent = 0;
		have = 1'b0;
		beat = '0;
		while (c >= thr && sent < FRAME_BURST) begin
			idx = pos;
			pos = (pos + 1 >= fc) ? 64'd0 : pos + 1;
			if (sent >= int'(bufs))
				break;
			if (have)
				pending_frames.push_back(beat);
			beat.frame_index = idx[IDX_W-1:0];
			beat.last = 1'b0;
			have = 1'b1;
			c = c - thr;
			sent++;
		end
		if (have) begin
			beat.last = 1'b1;
			pending_frames.push_back(beat);
		end
		cursor = pos[IDX_W-1:0];
		credit_acc = c[CREDIT_W-1:0];
	endfunction

	// one tick beat, with an optional gap in front of it
	task automatic send_tick(input logic [TIME_W-1:0] at_ns, input logic [BUF_W-1:0] bufs);
		if (idle_on && $urandom_range(0, 5) == 0) begin
			ticks.valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(negedge clk);
		end
		ticks.valid <= 1'b1;
		ticks.now_ns <= at_ns;
		ticks.free_buffers <= bufs;
		@(posedge clk);
		while (!ticks.ready) @(posedge clk);
		pace_frames(at_ns, bufs);
		ticks_sent++;
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [CFG_DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= index;
		cfg_wdata <= data;
		case (index)
			CFG_N_FRAMES:  pacer_cfg.n_frames = data[IDX_W-1:0];
			CFG_PKT_RATE:  pacer_cfg.pkt_rate = data[RATE_W-1:0];
			CFG_N_WORKERS: pacer_cfg.n_workers = data[WC_W-1:0];
			default: ;
		endcase
		cfg_writes++;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// wait for every expected beat, then let trailing ticks drain
	task automatic settle();
		ticks.valid <= 1'b0;
		while (pending_frames.size() != 0) @(negedge clk);
		repeat (QUIET_CYCLES) @(negedge clk);
	endtask

	// any zero register disables the pacer and leaves the clock unanchored
	task automatic test_disabled();
		send_tick(64'd1000, 7'd10);
		settle();
		write_reg(CFG_N_FRAMES, 32'd4);
		write_reg(CFG_PKT_RATE, 32'd1_000_000);
		send_tick(64'd2000, 7'd10);
		settle();
		write_reg(CFG_N_WORKERS, 32'd1);
		write_reg(CFG_PKT_RATE, 32'd0);
		send_tick(64'd3000, 7'd10);
	endtask

	// time zero keeps the clock unanchored, then rotation over three frames
	task automatic test_anchor_rotation();
		settle();
		write_reg(CFG_PKT_RATE, 32'd1_000_000);
		write_reg(CFG_N_FRAMES, 32'd3);
		send_tick(64'd0, 7'd64);
		send_tick(64'd10_000, 7'd64);
		send_tick(64'd15_000, 7'd64);
		send_tick(64'd16_500, 7'd2);
	endtask

	// earlier and equal timestamps give no elapsed time; zero drops the anchor
	task automatic test_time_backward();
		send_tick(64'd16_000, 7'd64);
		send_tick(64'd16_000, 7'd64);
		send_tick(64'd18_000, 7'd64);
		send_tick(64'd0, 7'd64);
		send_tick(64'd5_000, 7'd64);
	endtask

	// no buffers skips one frame, few buffers cut the burst short
	task automatic test_buffer_exhausted();
		send_tick(64'd25_000, 7'd0);
		send_tick(64'd28_000, 7'd3);
		send_tick(64'd29_000, 7'd127);
	endtask

	// product overflow at full-scale rate and workers
	task automatic test_saturation();
		settle();
		write_reg(CFG_PKT_RATE, 32'hFFFF_FFFF);
		write_reg(CFG_N_WORKERS, 32'd255);
		write_reg(CFG_N_FRAMES, 32'd65535);
		send_tick(64'hFFFF_FFFF_FFFF_FFFE, 7'd127);
		send_tick(64'hFFFF_FFFF_FFFF_FFFF, 7'd64);
	endtask

	// stored credit above a lowered cap, cursor folded onto a single frame
	task automatic test_cap_lowered();
		send_tick(64'h8000_0000_0000_0000, 7'd64);
		send_tick(64'h8000_0100_0000_0000, 7'd0);
		settle();
		write_reg(CFG_N_WORKERS, 32'd1);
		write_reg(CFG_N_FRAMES, 32'd1);
		send_tick(64'h8000_0100_0000_0001, 7'd64);
	endtask

	// one packet per second
	task automatic test_slowest_rate();
		settle();
		write_reg(CFG_PKT_RATE, 32'd1);
		write_reg(CFG_N_FRAMES, 32'd5);
		send_tick(64'h8000_0200_0000_0000, 7'd64);
		send_tick(64'h8000_0200_0000_0000 + 64'd3_000_000_000, 7'd64);
	endtask

	// random settings, tick spacing scaled to a few frames per tick
	task automatic test_random_traffic(input int phases, input int per_phase);
		logic [63:0]       thr;
		logic [63:0]       gap;
		logic [RATE_W-1:0] rate_v;
		logic [BUF_W-1:0]  bufs;
		int                sel;
		int                target;
		for (int p = 0; p < phases; p++) begin
			settle();
			sel = $urandom_range(0, 9);
			write_reg(CFG_N_FRAMES, sel == 0 ? 32'd1 : sel == 1 ? 32'd65535 :
				sel < 6 ? 32'($urandom_range(2, 12)) : 32'($urandom_range(1, 65535)));
			sel = $urandom_range(0, 9);
			write_reg(CFG_N_WORKERS, sel == 0 ? 32'd1 : sel == 1 ? 32'd255 :
				32'($urandom_range(1, 255)));
			case ($urandom_range(0, 3))
				0: rate_v = $urandom_range(1, 1000);
				1: rate_v = $urandom_range(1000, 1_000_000);
				2: rate_v = $urandom;
				default: rate_v = '1;
			endcase
			if (rate_v == 0)
				rate_v = 1;
			write_reg(CFG_PKT_RATE, rate_v);
			if ($urandom_range(0, 2) == 0)
				stim_ns = {$urandom, $urandom};
			thr = 64'(NS_PER_SEC) * 64'(pacer_cfg.n_workers);
			repeat (per_phase) begin
				sel = $urandom_range(0, 99);
				target = (sel < 5) ? $urandom_range(64, 200) : $urandom_range(0, 10);
				gap = (64'(target) * thr + ({$urandom, $urandom} % thr)) / 64'(rate_v);
				if (sel >= 5 && sel < 13)
					stim_ns = stim_ns - 64'($urandom_range(0, 5000));
				else if (sel == 13)
					stim_ns = '0;
				else
					stim_ns = stim_ns + gap;
				sel = $urandom_range(0, 9);
				if (sel < 7)
					bufs = BUF_W'($urandom_range(0, 64));
				else if (sel < 9)
					bufs = BUF_W'($urandom_range(0, 4));
				else
					bufs = BUF_W'($urandom_range(65, 127));
				send_tick(stim_ns, bufs);
			end
		end
	endtask

	// back-to-back ticks with the frame sink always ready
	task automatic test_steady_stream();
		settle();
		idle_on = 1'b0;
		test_random_traffic(1, 40);
	endtask

	// frame sink with random stall bursts
	always @(negedge clk) begin
		if (!arst_n) begin
			frames.ready <= 1'b0;
		end else if (stall_left > 0) begin
			frames.ready <= 1'b0;
			stall_left = stall_left - 1;
		end else if (idle_on && $urandom_range(0, 7) == 0) begin
			frames.ready <= 1'b0;
			stall_left = $urandom_range(0, 9);
		end else begin
			frames.ready <= 1'b1;
		end
	end

	// compare each frame beat with the oldest expectation
	always @(posedge clk) begin
		frame_beat_t want;
		if (arst_n && frames.valid && frames.ready) begin
			if (pending_frames.size() == 0) begin
				errors++;
				$display("%0t unexpected frame beat: expected none actual index %0d last %0b",
					$time, frames.frame_index, frames.last);
			end else begin
				want = pending_frames.pop_front();
				frames_checked++;
				if (frames.frame_index !== want.frame_index) begin
					errors++;
					$display("%0t frame_index mismatch: expected %0d actual %0d",
						$time, want.frame_index, frames.frame_index);
				end
				if (frames.last !== want.last) begin
					errors++;
					$display("%0t last mismatch: expected %0b actual %0b",
						$time, want.last, frames.last);
				end
			end
		end
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_N_FRAMES;
		cfg_wdata = '0;
		ticks.valid = 1'b0;
		ticks.now_ns = '0;
		ticks.free_buffers = '0;
		frames.ready = 1'b0;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;

		test_disabled();
		test_anchor_rotation();
		test_time_backward();
		test_buffer_exhausted();
		test_saturation();
		test_cap_lowered();
		test_slowest_rate();
		test_random_traffic(7, 40);
		test_steady_stream();
		settle();

		$display("ticks sent %0d, frame beats checked %0d", ticks_sent, frames_checked);
		$display("register writes %0d, disabled, zero-time, backward, overflow and skip cases",
			cfg_writes);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	// run limit
	initial begin
		#15_000_000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule
